[src/message_fifo_drop_oldest_macros.svh]
// Assertion helpers shared by the message FIFO modules.
`ifndef MESSAGE_FIFO_DROP_OLDEST_MACROS_SVH
`define MESSAGE_FIFO_DROP_OLDEST_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define MFDO_ASSERT_ALWAYS(name, clk_i, rstn_i, expr, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (expr)) \
        else $error(msg);

// A condition that must hold in the same cycle whenever the trigger holds.
`define MFDO_ASSERT_IMPLY(name, clk_i, rstn_i, ante, cons, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/mfdo_pkg.sv]
package mfdo_pkg;

    // Fixed field widths of the interface.
    localparam int ACT_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int CNT_OUT_W  = 5;
    localparam int CFG_ENT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 1'd1;

    // Configuration values after reset.
    localparam logic [CFG_ENT_W-1:0] MAX_ENTRIES_RST = 5'd0;
    localparam logic [LEN_W-1:0]     MAX_BYTES_RST   = 7'd64;

    // Command queue between the front and back ends.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;

    // Result queue at the output.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_COMMIT = 2'd1,
        ACT_POP    = 2'd2,
        ACT_PEEK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_TOO_LONG = 2'd2
    } status_t;

    // One classified item, as handed from the front end to the back end.
    typedef struct packed {
        logic                 is_read;
        status_t              status;
        logic                 drop;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        status_t              status;
        logic [BYTE_W-1:0]    data;
        logic                 byte_valid;
        logic                 last;
        logic [LEN_W-1:0]     length;
        logic                 drop;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty;
    } res_t;

    // Store write strobes from the front end.
    typedef struct packed {
        logic msg_we;
        logic len_we;
    } wr_ctl_t;

endpackage

[src/mfdo_front.sv]
`include "message_fifo_drop_oldest_macros.svh"

module mfdo_front
    import mfdo_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int MAX_LEN = 64,
    localparam int SLOTS  = DEPTH + 1,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int ADDR_W = $clog2(SLOTS * MAX_LEN)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [ACT_W-1:0]      action,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmdq_full,
    input  logic                  slot_busy,
    output logic [SLOT_W-1:0]     probe_slot,
    output logic                  cmd_push,
    output cmd_t                  cmd,
    output logic [SLOT_W-1:0]     cmd_slot,
    output wr_ctl_t               wr_ctl,
    output logic [ADDR_W-1:0]     msg_addr,
    output logic [BYTE_W-1:0]     msg_data,
    output logic [SLOT_W-1:0]     len_addr,
    output logic [LEN_W-1:0]      len_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = (CNT_W > CFG_ENT_W) ? CNT_W : CFG_ENT_W;

    logic [CFG_ENT_W-1:0] max_ent_reg;
    logic [LEN_W-1:0]     max_bytes_reg;
    logic [SLOT_W-1:0]    read_slot_reg, read_slot_next;
    logic [SLOT_W-1:0]    write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [LEN_W-1:0]     staged_reg, staged_next;

    logic                 acc;
    logic                 drop;
    logic [SLOT_W-1:0]    read_slot_inc;
    logic [SLOT_W-1:0]    write_slot_inc;
    logic [LEN_W-1:0]     len_lim;
    logic [ENT_W-1:0]     ent_lim;
    logic [ENT_W-1:0]     max_ent_ext;
    logic [ENT_W-1:0]     held_ext;

    // Stall while the command queue is full or the staging slot is still being read.
    assign full = cmdq_full | slot_busy;
    assign acc  = push & ~full;

    // Ring pointer increments over the slots.
    assign read_slot_inc  = (read_slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                                                  : read_slot_reg + 1'b1;
    assign write_slot_inc = (write_slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                                                   : write_slot_reg + 1'b1;

    // Effective limits after clamping to the built capacity.
    assign len_lim     = (max_bytes_reg > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : max_bytes_reg;
    assign max_ent_ext = ENT_W'(max_ent_reg);
    assign held_ext    = ENT_W'(held_reg);
    assign ent_lim     = (max_ent_reg == '0 || max_ent_ext > ENT_W'(DEPTH)) ? ENT_W'(DEPTH)
                                                                         : max_ent_ext;

    // Store write ports always point at the staging slot.
    assign msg_addr   = ADDR_W'(write_slot_reg) * ADDR_W'(MAX_LEN) + ADDR_W'(staged_reg);
    assign msg_data   = data_byte;
    assign len_addr   = write_slot_reg;
    assign len_data   = staged_reg;
    assign probe_slot = write_slot_reg;
    assign cmd_slot   = read_slot_reg;
    assign cmd_push   = acc;

    // Classify the item and update the queue bookkeeping.
    always_comb
    begin
        read_slot_next  = read_slot_reg;
        write_slot_next = write_slot_reg;
        held_next       = held_reg;
        staged_next     = staged_reg;
        drop            = 1'b0;
        wr_ctl          = '0;
        cmd             = '0;
        cmd.status      = STAT_OK;
        if (acc)
        begin
            unique case (action_t'(action)) inside
                ACT_APPEND:
                begin
                    if (staged_reg < len_lim)
                    begin
                        wr_ctl.msg_we = 1'b1;
                        staged_next   = staged_reg + 1'b1;
                    end
                    else
                    begin
                        cmd.status = STAT_TOO_LONG;
                    end
                end
                ACT_COMMIT:
                begin
                    if (held_ext >= ent_lim && held_reg != '0)
                    begin
                        drop           = 1'b1;
                        read_slot_next = read_slot_inc;
                    end
                    held_next       = drop ? held_reg : held_reg + 1'b1;
                    wr_ctl.len_we   = 1'b1;
                    write_slot_next = write_slot_inc;
                    staged_next     = '0;
                    cmd.drop        = drop;
                end
                ACT_POP, ACT_PEEK:
                begin
                    if (held_reg == '0)
                    begin
                        cmd.status = STAT_EMPTY;
                    end
                    else
                    begin
                        cmd.is_read = 1'b1;
                        if (action_t'(action) == ACT_POP)
                        begin
                            read_slot_next = read_slot_inc;
                            held_next      = held_reg - 1'b1;
                        end
                    end
                end
            endcase
        end
        cmd.count = CNT_OUT_W'(held_next);
        cmd.empty = (held_next == '0);
    end

    // Queue state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_slot_reg  <= '0;
            write_slot_reg <= '0;
            held_reg       <= '0;
            staged_reg     <= '0;
        end
        else
        begin
            read_slot_reg  <= read_slot_next;
            write_slot_reg <= write_slot_next;
            held_reg       <= held_next;
            staged_reg     <= staged_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ent_reg   <= MAX_ENTRIES_RST;
            max_bytes_reg <= MAX_BYTES_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_ENTRIES: max_ent_reg   <= cfg_data[CFG_ENT_W-1:0];
                CFG_MAX_BYTES:   max_bytes_reg <= cfg_data;
            endcase
        end
    end

    `MFDO_ASSERT_ALWAYS(a_held_bound, clk, rst_n, held_reg <= CNT_W'(DEPTH), "held count above depth")
    `MFDO_ASSERT_ALWAYS(a_staged_bound, clk, rst_n, staged_reg <= LEN_W'(MAX_LEN), "staged length above maximum")

endmodule

[src/mfdo_cmdq.sv]
module mfdo_cmdq
    import mfdo_pkg::*;
#(
    parameter int DEPTH   = 16,
    localparam int SLOT_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cmd_t              cmd_in,
    input  logic [SLOT_W-1:0] slot_in,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output cmd_t              cmd_out,
    output logic [SLOT_W-1:0] slot_out,
    input  logic [SLOT_W-1:0] probe_slot,
    output logic              slot_busy
);

    cmd_t                  cmd_reg  [CMDQ_DEPTH];
    logic [SLOT_W-1:0]     slot_reg [CMDQ_DEPTH];
    logic [CMDQ_DEPTH-1:0] valid_reg, valid_next;
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;

    assign full     = valid_reg[wr_ptr_reg];
    assign empty    = ~valid_reg[rd_ptr_reg];
    assign cmd_out  = cmd_reg[rd_ptr_reg];
    assign slot_out = slot_reg[rd_ptr_reg];

    // A queued read of the probed slot must finish before that slot is rewritten.
    always_comb
    begin
        slot_busy = 1'b0;
        for (int i = 0; i < CMDQ_DEPTH; i++)
        begin
            if (valid_reg[i] && cmd_reg[i].is_read && slot_reg[i] == probe_slot)
            begin
                slot_busy = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next[wr_ptr_reg] = 1'b1;
        end
        if (pop)
        begin
            valid_next[rd_ptr_reg] = 1'b0;
        end
    end

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wr_ptr_reg]  <= cmd_in;
            slot_reg[wr_ptr_reg] <= slot_in;
        end
    end

    // Occupancy and pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

[src/mfdo_back.sv]
`include "message_fifo_drop_oldest_macros.svh"

module mfdo_back
    import mfdo_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int MAX_LEN = 64,
    localparam int SLOTS  = DEPTH + 1,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int ADDR_W = $clog2(SLOTS * MAX_LEN)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmdq_empty,
    input  cmd_t              cmd_in,
    input  logic [SLOT_W-1:0] cmd_slot,
    output logic              cmd_pop,
    input  wr_ctl_t           wr_ctl,
    input  logic [ADDR_W-1:0] msg_addr,
    input  logic [BYTE_W-1:0] msg_data,
    input  logic [SLOT_W-1:0] len_addr,
    input  logic [LEN_W-1:0]  len_data,
    input  logic [SLOT_W-1:0] probe_slot,
    output logic              slot_busy,
    input  logic              pop,
    output logic              empty,
    output res_t              res
);

    localparam int MEM_DEPTH = SLOTS * MAX_LEN;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_LEN   = 3'b010,
        BK_BYTES = 3'b100
    } bk_state_t;

    logic [BYTE_W-1:0] msg_mem [MEM_DEPTH];
    logic [LEN_W-1:0]  len_mem [SLOTS];

    bk_state_t            state_reg, state_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [CNT_OUT_W-1:0] count_reg;
    logic                 empty_reg;
    logic [LEN_W-1:0]     len_q_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     idx_reg;
    logic [BYTE_W-1:0]    msg_q_reg;
    logic                 rd_valid_reg;
    logic                 rd_last_reg;

    res_t                 oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  oq_wp_reg, oq_rp_reg;
    logic [OQ_CNT_W-1:0]  oq_cnt_reg;

    logic                 room;
    logic                 issue;
    logic                 rd_last;
    logic                 dpush;
    res_t                 dres;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 oq_push;
    logic                 oq_pop;
    res_t                 oq_in;

    // Room for one more beat counting the read that is in flight.
    assign room    = (oq_cnt_reg + OQ_CNT_W'(rd_valid_reg)) <= OQ_CNT_W'(OQ_DEPTH - 2);
    assign rd_addr = base_reg + ADDR_W'(idx_reg);

    // The slot being read may not be rewritten until its last byte is fetched.
    assign slot_busy = (state_reg != BK_IDLE) && (slot_reg == probe_slot);

    // Sequencer: single results go straight out, reads walk the message.
    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        dpush      = 1'b0;
        dres       = '0;
        dres.last  = 1'b1;
        issue      = 1'b0;
        rd_last    = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmdq_empty && room && !rd_valid_reg)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_in.is_read)
                    begin
                        state_next = BK_LEN;
                    end
                    else
                    begin
                        dpush       = 1'b1;
                        dres.status = cmd_in.status;
                        dres.drop   = cmd_in.drop;
                        dres.count  = cmd_in.count;
                        dres.empty  = cmd_in.empty;
                    end
                end
            end
            BK_LEN:
            begin
                if (len_q_reg == '0)
                begin
                    if (room)
                    begin
                        dpush       = 1'b1;
                        dres.status = STAT_OK;
                        dres.count  = count_reg;
                        dres.empty  = empty_reg;
                        state_next  = BK_IDLE;
                    end
                end
                else
                begin
                    state_next = BK_BYTES;
                end
            end
            BK_BYTES:
            begin
                if (room)
                begin
                    issue   = 1'b1;
                    rd_last = (LEN_W'(idx_reg + 1'b1) == len_reg);
                    if (rd_last)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Message and length stores.
    always_ff @(posedge clk)
    begin
        if (wr_ctl.msg_we)
        begin
            msg_mem[msg_addr] <= msg_data;
        end
        if (issue)
        begin
            msg_q_reg <= msg_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ctl.len_we)
        begin
            len_mem[len_addr] <= len_data;
        end
        if (cmd_pop)
        begin
            len_q_reg <= len_mem[cmd_slot];
        end
    end

    // Per-read context.
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd_in.is_read)
        begin
            slot_reg  <= cmd_slot;
            base_reg  <= ADDR_W'(cmd_slot) * ADDR_W'(MAX_LEN);
            count_reg <= cmd_in.count;
            empty_reg <= cmd_in.empty;
        end
        if (state_reg == BK_LEN)
        begin
            len_reg <= len_q_reg;
            idx_reg <= '0;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (issue)
        begin
            rd_last_reg <= rd_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
        end
    end

    // Result queue: a fetched byte or a single result enters it, never both at once.
    always_comb
    begin
        if (rd_valid_reg)
        begin
            oq_in            = '0;
            oq_in.status     = STAT_OK;
            oq_in.data       = msg_q_reg;
            oq_in.byte_valid = 1'b1;
            oq_in.last       = rd_last_reg;
            oq_in.length     = len_reg;
            oq_in.count      = count_reg;
            oq_in.empty      = empty_reg;
        end
        else
        begin
            oq_in = dres;
        end
    end

    assign oq_push = rd_valid_reg | dpush;
    assign oq_pop  = pop & (oq_cnt_reg != '0);
    assign empty   = (oq_cnt_reg == '0);
    assign res     = oq_reg[oq_rp_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wp_reg] <= oq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wp_reg  <= '0;
            oq_rp_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wp_reg <= oq_wp_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rp_reg <= oq_rp_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_reg + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
        end
    end

    `MFDO_ASSERT_ALWAYS(a_oq_bound, clk, rst_n, oq_cnt_reg <= OQ_CNT_W'(OQ_DEPTH), "result queue overflow")
    `MFDO_ASSERT_IMPLY(a_no_push_clash, clk, rst_n, rd_valid_reg, !dpush, "two beats pushed in one cycle")
    `MFDO_ASSERT_IMPLY(a_idx_range, clk, rst_n, state_reg == BK_BYTES, idx_reg < len_reg, "byte index past message end")

endmodule

[src/message_fifo_drop_oldest.sv]
// Message FIFO with drop-oldest overflow.
// Input channel: push/full with action and data_byte. An item is taken at a
// clock edge where push is high and full is low. Appends stage a byte, a
// commit queues the staged message, pop and peek read the head message.
// Result channel: empty/pop. The oldest result sits on the result ports while
// empty is low and is taken at an edge where pop is high.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while the block is idle.
// An append, commit or empty-queue result goes via the command queue to the
// result queue; a pop or peek reads its length, then its bytes in turn.
// One single-result item per cycle while results are taken; a pop or peek
// holds the read sequencer until its last byte is fetched, one byte per cycle
// while the result queue has room, set by the store's single read port. Full
// also rises while an earlier pop or peek still reads the staging slot.
// Reset empties the queue, clears the staged message and sets the entry limit
// to 0 and the length limit to 64. When the receiver stalls, the result queue
// takes up to three beats and then the four-entry command queue fills before
// full rises.
module message_fifo_drop_oldest
    import mfdo_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int MAX_LEN = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [ACT_W-1:0]      action,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            status,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  byte_valid,
    output logic                  last,
    output logic [LEN_W-1:0]      message_length,
    output logic                  dropped_oldest,
    output logic [CNT_OUT_W-1:0]  entry_count,
    output logic                  is_empty
);

    localparam int SLOTS  = DEPTH + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ADDR_W = $clog2(SLOTS * MAX_LEN);

    logic              cmdq_full;
    logic              cmdq_empty;
    logic              cmd_push;
    logic              cmd_pop;
    cmd_t              cmd_f;
    cmd_t              cmd_b;
    logic [SLOT_W-1:0] slot_f;
    logic [SLOT_W-1:0] slot_b;
    logic [SLOT_W-1:0] probe_slot;
    logic              busy_q;
    logic              busy_b;
    wr_ctl_t           wr_ctl;
    logic [ADDR_W-1:0] msg_addr;
    logic [BYTE_W-1:0] msg_data;
    logic [SLOT_W-1:0] len_addr;
    logic [LEN_W-1:0]  len_data;
    res_t              res;

    assign cfg_ready = 1'b1;

    // Front end: takes items, keeps queue state, writes the stores.
    mfdo_front #(
        .DEPTH   (DEPTH),
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .data_byte  (data_byte),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmdq_full  (cmdq_full),
        .slot_busy  (busy_q | busy_b),
        .probe_slot (probe_slot),
        .cmd_push   (cmd_push),
        .cmd        (cmd_f),
        .cmd_slot   (slot_f),
        .wr_ctl     (wr_ctl),
        .msg_addr   (msg_addr),
        .msg_data   (msg_data),
        .len_addr   (len_addr),
        .len_data   (len_data)
    );

    // Command queue between the two ends.
    mfdo_cmdq #(
        .DEPTH (DEPTH)
    ) u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .cmd_in     (cmd_f),
        .slot_in    (slot_f),
        .full       (cmdq_full),
        .pop        (cmd_pop),
        .empty      (cmdq_empty),
        .cmd_out    (cmd_b),
        .slot_out   (slot_b),
        .probe_slot (probe_slot),
        .slot_busy  (busy_q)
    );

    // Back end: stores, read sequencer and result queue.
    mfdo_back #(
        .DEPTH   (DEPTH),
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmdq_empty (cmdq_empty),
        .cmd_in     (cmd_b),
        .cmd_slot   (slot_b),
        .cmd_pop    (cmd_pop),
        .wr_ctl     (wr_ctl),
        .msg_addr   (msg_addr),
        .msg_data   (msg_data),
        .len_addr   (len_addr),
        .len_data   (len_data),
        .probe_slot (probe_slot),
        .slot_busy  (busy_b),
        .pop        (pop),
        .empty      (empty),
        .res        (res)
    );

    assign status         = res.status;
    assign out_byte       = res.data;
    assign byte_valid     = res.byte_valid;
    assign last           = res.last;
    assign message_length = res.length;
    assign dropped_oldest = res.drop;
    assign entry_count    = res.count;
    assign is_empty       = res.empty;

endmodule

[test/testbench.sv]
module testbench;
    import mfdo_pkg::*;

    localparam int DEPTH      = 16;
    localparam int MAX_LEN    = 64;
    localparam int SLOTS      = DEPTH + 1;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_ITEMS = 45;
    localparam int LONG_STALL = 300;
    localparam int SETTLE_CYCLES = 8;

    // Block ports; the inputs are driven to known values from time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    logic [ACT_W-1:0]      action    = '0;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic [1:0]            status;
    logic [BYTE_W-1:0]     out_byte;
    logic                  byte_valid;
    logic                  last;
    logic [LEN_W-1:0]      message_length;
    logic                  dropped_oldest;
    logic [CNT_OUT_W-1:0]  entry_count;
    logic                  is_empty;

    message_fifo_drop_oldest #(
        .DEPTH   (DEPTH),
        .MAX_LEN (MAX_LEN)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .action         (action),
        .data_byte      (data_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .last           (last),
        .message_length (message_length),
        .dropped_oldest (dropped_oldest),
        .entry_count    (entry_count),
        .is_empty       (is_empty)
    );

    // One row of the directed table: either a register write or an item.
    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        action_t               act;
        logic [BYTE_W-1:0]     din;
        bit                    typed;
        res_t                  want;
    } dir_row_t;

    // Mirror of the message ring and its bookkeeping.
    logic [BYTE_W-1:0] mirror_bytes [0:SLOTS*MAX_LEN-1];
    int                mirror_len   [0:SLOTS-1];
    int                head_slot    = 0;
    int                tail_slot    = 0;
    int                held         = 0;
    int                staged       = 0;
    int                lim_entries  = int'(MAX_ENTRIES_RST);
    int                lim_bytes    = int'(MAX_BYTES_RST);

    res_t     pending_beats [$];
    dir_row_t directed_rows [$];
    int       mismatches      = 0;
    bit       idle_allowed    = 1'b1;
    bit       long_stall_req  = 1'b0;
    bit       long_stall_done = 1'b0;

    // Register settings for the first six phases; the last is fixed, the rest random.
    int phase_entries [0:5] = '{16, 3, 0, 31, 1, 8};
    int phase_bytes   [0:5] = '{64, 5, 127, 64, 0, 8};
    int phase_pop_pct [0:NUM_PHASES-1] = '{5, 30, 10, 10, 40, 30, 30, 30, 50};

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #10000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic res_t mk_beat(status_t st, logic [BYTE_W-1:0] b, logic v, logic l,
                                     logic [LEN_W-1:0] len, logic dr,
                                     logic [CNT_OUT_W-1:0] cnt, logic emp);
        res_t r;
        r.status     = st;
        r.data       = b;
        r.byte_valid = v;
        r.last       = l;
        r.length     = len;
        r.drop       = dr;
        r.count      = cnt;
        r.empty      = emp;
        return r;
    endfunction

    // A beat that carries the held count as it stands now.
    function automatic res_t held_beat(status_t st, logic [BYTE_W-1:0] b, logic v, logic l,
                                       logic [LEN_W-1:0] len, logic dr);
        return mk_beat(st, b, v, l, len, dr, CNT_OUT_W'(held), held == 0);
    endfunction

    function automatic int next_slot(int s);
        return (s + 1 >= SLOTS) ? 0 : s + 1;
    endfunction

    // Work out the result beats of one accepted item and queue them.
    task automatic mirror_fifo_action(input action_t act, input logic [BYTE_W-1:0] din);
        int  byte_cap;
        int  entry_cap;
        int  slot;
        int  len;
        logic dr;
        case (act)
            ACT_APPEND:
            begin
                byte_cap = (lim_bytes > MAX_LEN) ? MAX_LEN : lim_bytes;
                if (staged < byte_cap)
                begin
                    mirror_bytes[tail_slot*MAX_LEN + staged] = din;
                    staged++;
                    pending_beats.push_back(held_beat(STAT_OK, 8'h00, 1'b0, 1'b1, 7'd0, 1'b0));
                end
                else
                begin
                    // A byte past the length limit is dropped and flagged.
                    pending_beats.push_back(held_beat(STAT_TOO_LONG, 8'h00, 1'b0, 1'b1, 7'd0,
                                                      1'b0));
                end
            end
            ACT_COMMIT:
            begin
                entry_cap = (lim_entries == 0 || lim_entries > DEPTH) ? DEPTH : lim_entries;
                dr = 1'b0;
                if (held >= entry_cap && held > 0)
                begin
                    head_slot = next_slot(head_slot);
                    held--;
                    dr = 1'b1;
                end
                mirror_len[tail_slot] = staged;
                tail_slot = next_slot(tail_slot);
                held++;
                staged = 0;
                pending_beats.push_back(held_beat(STAT_OK, 8'h00, 1'b0, 1'b1, 7'd0, dr));
            end
            default:
            begin
                if (held == 0)
                begin
                    pending_beats.push_back(held_beat(STAT_EMPTY, 8'h00, 1'b0, 1'b1, 7'd0, 1'b0));
                end
                else
                begin
                    slot = head_slot;
                    len  = (mirror_len[slot] > MAX_LEN) ? MAX_LEN : mirror_len[slot];
                    if (act == ACT_POP)
                    begin
                        head_slot = next_slot(head_slot);
                        held--;
                    end
                    if (len == 0)
                    begin
                        pending_beats.push_back(held_beat(STAT_OK, 8'h00, 1'b0, 1'b1, 7'd0,
                                                          1'b0));
                    end
                    else
                    begin
                        for (int i = 0; i < len; i++)
                        begin
                            pending_beats.push_back(held_beat(STAT_OK,
                                mirror_bytes[slot*MAX_LEN + i], 1'b1, i == len - 1,
                                LEN_W'(len), 1'b0));
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string field_name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h, want %0h", field_name, got, want));
        end
    endtask

    // Compare one accepted result beat with the oldest expectation.
    task automatic check_beat();
        res_t want;
        if (pending_beats.size() == 0)
        begin
            report_mismatch("result beat with nothing expected");
        end
        else
        begin
            want = pending_beats.pop_front();
            compare_field("status", 8'(status), 8'(want.status));
            compare_field("out_byte", out_byte, want.data);
            compare_field("byte_valid", 8'(byte_valid), 8'(want.byte_valid));
            compare_field("last", 8'(last), 8'(want.last));
            compare_field("message_length", 8'(message_length), 8'(want.length));
            compare_field("dropped_oldest", 8'(dropped_oldest), 8'(want.drop));
            compare_field("entry_count", 8'(entry_count), 8'(want.count));
            compare_field("is_empty", 8'(is_empty), 8'(want.empty));
        end
    endtask

    // Offer one item until the block takes it, then predict its results.
    task automatic send_item(input action_t act, input logic [BYTE_W-1:0] din,
                             input bit use_typed, input res_t typed_beat);
        if (idle_allowed && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push      <= 1'b1;
        action    <= act;
        data_byte <= din;
        @(posedge clk);
        while (full !== 1'b0) @(posedge clk);
        mirror_fifo_action(act, din);
        if (use_typed)
        begin
            void'(pending_beats.pop_back());
            pending_beats.push_back(typed_beat);
        end
    endtask

    // Stop sending and wait for every expected beat, then for the pipeline.
    task automatic settle();
        push <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_ENTRIES)
        begin
            lim_entries = int'(val[CFG_ENT_W-1:0]);
        end
        else
        begin
            lim_bytes = int'(val);
        end
    endtask

    function automatic void add_item(action_t act, logic [BYTE_W-1:0] din);
        dir_row_t r;
        r = '0;
        r.act = act;
        r.din = din;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_typed(action_t act, logic [BYTE_W-1:0] din, res_t want);
        dir_row_t r;
        r = '0;
        r.act   = act;
        r.din   = din;
        r.typed = 1'b1;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.is_cfg    = 1'b1;
        r.reg_index = idx;
        r.reg_value = val;
        directed_rows.push_back(r);
    endfunction

    // Result side: random short stalls, plus one long hold-off on request.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && empty === 1'b0)
            begin
                check_beat();
            end
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (long_stall_req && !long_stall_done)
            begin
                hold_left = LONG_STALL;
                long_stall_done = 1'b1;
            end
            else if (idle_allowed && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 4);
            end
            pop <= (hold_left == 0);
        end
    end

    // Stimulus: directed table, then random phases under varying limits.
    initial begin : stimulus
        dir_row_t row;
        int       e;
        int       b;
        int       sent;
        int       roll;
        int       msg_len;
        action_t  act;

        // Directed rows, starting from the reset limits.
        add_typed(ACT_POP, 8'h00, mk_beat(STAT_EMPTY, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_PEEK, 8'hFF, mk_beat(STAT_EMPTY, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_COMMIT, 8'hC3, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 1, 0));
        add_typed(ACT_PEEK, 8'h00, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 1, 0));
        add_typed(ACT_POP, 8'h00, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_APPEND, 8'h00, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_APPEND, 8'hFF, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_APPEND, 8'hA5, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_COMMIT, 8'h3C, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 1, 0));
        add_item(ACT_PEEK, 8'h00);
        add_item(ACT_POP, 8'h00);
        // Length limit reached, then lowered while bytes are staged.
        add_cfg(CFG_MAX_BYTES, 7'd2);
        add_typed(ACT_APPEND, 8'h5A, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_APPEND, 8'h3C, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_APPEND, 8'h77, mk_beat(STAT_TOO_LONG, 8'h00, 0, 1, 0, 0, 0, 1));
        add_cfg(CFG_MAX_BYTES, 7'd1);
        add_typed(ACT_COMMIT, 8'h00, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 1, 0));
        add_item(ACT_POP, 8'h00);
        // Entry limit of one forces a drop; zero length limit rejects every byte.
        add_cfg(CFG_MAX_ENTRIES, 7'd1);
        add_cfg(CFG_MAX_BYTES, 7'd0);
        add_typed(ACT_APPEND, 8'h01, mk_beat(STAT_TOO_LONG, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_COMMIT, 8'h00, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 1, 0));
        add_typed(ACT_COMMIT, 8'h00, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 1, 1, 0));
        add_typed(ACT_POP, 8'h00, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 0, 1));
        // Length limit above the slot size acts as the slot size.
        add_cfg(CFG_MAX_BYTES, 7'd127);
        add_typed(ACT_APPEND, 8'h80, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 0, 1));
        add_typed(ACT_COMMIT, 8'h00, mk_beat(STAT_OK, 8'h00, 0, 1, 0, 0, 1, 0));
        add_item(ACT_PEEK, 8'h00);
        add_item(ACT_POP, 8'h00);

        // Reset, released on a clock edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                write_reg(row.reg_index, row.reg_value);
            end
            else
            begin
                send_item(row.act, row.din, row.typed, row.want);
            end
        end

        // Random phases; each waits for the block to drain before new limits.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 6)
            begin
                e = phase_entries[p];
                b = phase_bytes[p];
            end
            else
            begin
                e = $urandom_range(0, 31);
                b = $urandom_range(0, 127);
            end
            if (p == NUM_PHASES - 1)
            begin
                e = 0;
                b = MAX_LEN;
                idle_allowed = 1'b0;
            end
            write_reg(CFG_MAX_ENTRIES, CFG_DATA_W'(e));
            write_reg(CFG_MAX_BYTES, CFG_DATA_W'(b));
            if (p == 3)
            begin
                long_stall_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < phase_pop_pct[p])
                begin
                    act = ($urandom_range(0, 2) == 0) ? ACT_PEEK : ACT_POP;
                    send_item(act, 8'($urandom_range(0, 255)), 1'b0, '0);
                    sent++;
                end
                else if (roll < phase_pop_pct[p] + 15)
                begin
                    // Noise: any action with any byte.
                    act = action_t'($urandom_range(0, 3));
                    send_item(act, 8'($urandom_range(0, 255)), 1'b0, '0);
                    sent++;
                end
                else
                begin
                    // A whole message: mostly short, now and then past the limit.
                    msg_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MAX_LEN + 6)
                                                           : $urandom_range(0, 6);
                    for (int k = 0; k < msg_len; k++)
                    begin
                        send_item(ACT_APPEND, 8'($urandom_range(0, 255)), 1'b0, '0);
                    end
                    send_item(ACT_COMMIT, 8'($urandom_range(0, 255)), 1'b0, '0);
                    sent += msg_len + 1;
                end
            end
        end

        // Drain and give the pipeline time to show any stray beat.
        settle();
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
